[rtl/core/sdve_pkg.sv]
// ----------------------------------------------------------------------------
// sdve_pkg
// Shared types and constants for the sensor delta varint encoder.
// ----------------------------------------------------------------------------
package sdve_pkg;

  localparam int unsigned DATA_W        = 32;
  localparam int unsigned IDX_W         = 4;
  localparam int unsigned THR_W         = 31;
  localparam int unsigned MASK_W        = 16;
  localparam int unsigned CFG_DATA_W    = 31;
  localparam int unsigned CFG_IDX_W     = 1;
  localparam int unsigned SENSOR_COUNT  = 10;

  localparam logic [THR_W-1:0]  THR_RESET  = THR_W'(1);
  localparam logic [MASK_W-1:0] MASK_RESET = '0;

  localparam logic [7:0] RESYNC_MARK = 8'hFF;
  localparam logic [6:0] GROUP_MASK  = 7'h7F;
  localparam logic [7:0] MORE_FLAG   = 8'h80;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_THRESHOLD = 1'b0,
    REG_IGNORE    = 1'b1
  } cfg_reg_t;

  typedef enum logic {
    KIND_DELTA  = 1'b0,
    KIND_RESYNC = 1'b1
  } kind_t;

  typedef struct packed {
    logic              en;
    logic [IDX_W-1:0]  addr;
    logic [DATA_W-1:0] data;
  } ref_wr_t;

  function automatic logic [DATA_W-1:0] zigzag(input logic [DATA_W-1:0] v);
    zigzag = {v[DATA_W-2:0], 1'b0} ^ {DATA_W{v[DATA_W-1]}};
  endfunction

endpackage

[rtl/core/sensor_delta_varint_encoder.sv]
// Sequence: a resync passes from accept through S_LOOK to S_MARK, a delta
//   through S_LOOK, S_MAG and S_CMP to S_IDX, before the first byte is sent.
// Throughput: one item at a time, one output byte per cycle while out_stall
//   is low; a new item is taken only once the last is done, as the shared
//   subtractor serves difference, negate and compare in turn.
// Reset: rst_n clears all known bits, the threshold to 1 and the ignore mask.
// ----------------------------------------------------------------------------
// sensor_delta_varint_encoder
// Delta/resync sample encoder emitting zigzag LEB128 varint records.
// ----------------------------------------------------------------------------
module sensor_delta_varint_encoder #(
  parameter int unsigned SENSOR_COUNT = sdve_pkg::SENSOR_COUNT
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [sdve_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [sdve_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              in_kind,
  input  logic [sdve_pkg::IDX_W-1:0]        in_sensor_index,
  input  logic signed [sdve_pkg::DATA_W-1:0] in_sample_value,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [7:0]                        out_byte,
  output logic                              out_last_byte
);

  typedef enum logic [2:0] {
    S_IDLE, S_LOOK, S_MAG, S_CMP, S_MARK, S_IDX, S_VAR
  } state_t;

  state_t                          state_r, state_nxt;
  logic [sdve_pkg::THR_W-1:0]      thr_r;
  logic [sdve_pkg::MASK_W-1:0]     ignore_r;
  logic                            kind_r, kind_nxt;
  logic [sdve_pkg::IDX_W-1:0]      idx_r, idx_nxt;
  logic [sdve_pkg::DATA_W-1:0]     val_r, val_nxt;
  logic [sdve_pkg::DATA_W-1:0]     work_r, work_nxt;
  logic                            out_valid_r, out_valid_nxt;
  logic [7:0]                      out_byte_r, out_byte_nxt;
  logic                            out_last_r, out_last_nxt;

  logic [sdve_pkg::DATA_W-1:0]     alu_a, alu_b, alu_diff;
  logic                            alu_nb;
  logic [sdve_pkg::DATA_W-1:0]     ref_value;
  logic                            ref_known;
  logic [sdve_pkg::IDX_W-1:0]      rd_idx;
  sdve_pkg::ref_wr_t               ref_wr;
  logic                            in_take, out_free, in_range, var_last;

  assign in_take  = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;
  assign in_range = ({1'b0, idx_r} < (sdve_pkg::IDX_W + 1)'(SENSOR_COUNT));
  assign var_last = (work_r[sdve_pkg::DATA_W-1:7] == '0);
  assign rd_idx   = (state_r == S_IDLE) ? in_sensor_index : idx_r;

  sdve_ref_store #(.SENSOR_COUNT(SENSOR_COUNT)) u_store (
    .clk      (clk),
    .rst_n    (rst_n),
    .rd_addr  (rd_idx),
    .rd_value (ref_value),
    .rd_known (ref_known),
    .wr       (ref_wr)
  );

  sdve_alu u_alu (
    .op_a      (alu_a),
    .op_b      (alu_b),
    .diff      (alu_diff),
    .no_borrow (alu_nb)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r    <= sdve_pkg::THR_RESET;
      ignore_r <= sdve_pkg::MASK_RESET;
    end else if (cfg_we) begin
      unique case (sdve_pkg::cfg_reg_t'(cfg_index))
        sdve_pkg::REG_THRESHOLD: thr_r    <= cfg_wdata;
        sdve_pkg::REG_IGNORE:    ignore_r <= cfg_wdata[sdve_pkg::MASK_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    state_nxt     = state_r;
    kind_nxt      = kind_r;
    idx_nxt       = idx_r;
    val_nxt       = val_r;
    work_nxt      = work_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_byte_nxt  = out_byte_r;
    out_last_nxt  = out_last_r;
    alu_a         = '0;
    alu_b         = '0;
    ref_wr.en     = 1'b0;
    ref_wr.addr   = idx_r;
    ref_wr.data   = val_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_take) begin
          kind_nxt  = in_kind;
          idx_nxt   = in_sensor_index;
          val_nxt   = in_sample_value;
          state_nxt = S_LOOK;
        end
      end
      S_LOOK: begin
        alu_a    = val_r;
        alu_b    = ref_value;
        work_nxt = alu_diff;
        if (!in_range) begin
          state_nxt = S_IDLE;
        end else if (kind_r == sdve_pkg::KIND_RESYNC) begin
          if (ignore_r[idx_r]) begin
            state_nxt = S_IDLE;
          end else begin
            ref_wr.en = 1'b1;
            work_nxt  = sdve_pkg::zigzag(val_r);
            state_nxt = S_MARK;
          end
        end else if (!ref_known) begin
          ref_wr.en = 1'b1;
          state_nxt = S_IDLE;
        end else begin
          state_nxt = S_MAG;
        end
      end
      S_MAG: begin
        alu_a     = '0;
        alu_b     = work_r;
        val_nxt   = work_r[sdve_pkg::DATA_W-1] ? alu_diff : work_r;
        work_nxt  = val_r;
        state_nxt = S_CMP;
      end
      S_CMP: begin
        alu_a    = val_r;
        alu_b    = {1'b0, thr_r};
        val_nxt  = work_r;
        work_nxt = sdve_pkg::zigzag(work_r - ref_value);
        if (!alu_nb) begin
          state_nxt = S_IDLE;
        end else begin
          ref_wr.en   = 1'b1;
          ref_wr.data = work_r;
          state_nxt   = S_IDX;
        end
      end
      S_MARK: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_byte_nxt  = sdve_pkg::RESYNC_MARK;
          out_last_nxt  = 1'b0;
          state_nxt     = S_IDX;
        end
      end
      S_IDX: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_byte_nxt  = 8'(idx_r);
          out_last_nxt  = 1'b0;
          state_nxt     = S_VAR;
        end
      end
      S_VAR: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_byte_nxt  = {1'b0, work_r[6:0] & sdve_pkg::GROUP_MASK} |
                          (var_last ? 8'h00 : sdve_pkg::MORE_FLAG);
          out_last_nxt  = var_last;
          work_nxt      = work_r >> 7;
          if (var_last) begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
    kind_r     <= kind_nxt;
    idx_r      <= idx_nxt;
    val_r      <= val_nxt;
    work_r     <= work_nxt;
    out_byte_r <= out_byte_nxt;
    out_last_r <= out_last_nxt;
  end

  assign in_stall      = (state_r != S_IDLE);
  assign out_valid     = out_valid_r;
  assign out_byte      = out_byte_r;
  assign out_last_byte = out_last_r;

endmodule

[rtl/core/sdve_ref_store.sv]
// ----------------------------------------------------------------------------
// sdve_ref_store
// Per-sensor reference values with known bits; registered read port.
// ----------------------------------------------------------------------------
module sdve_ref_store #(
  parameter int unsigned SENSOR_COUNT = sdve_pkg::SENSOR_COUNT
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic [sdve_pkg::IDX_W-1:0]       rd_addr,
  output logic [sdve_pkg::DATA_W-1:0]      rd_value,
  output logic                             rd_known,
  input  sdve_pkg::ref_wr_t                wr
);

  localparam int unsigned AW = (SENSOR_COUNT > 1) ? $clog2(SENSOR_COUNT) : 1;

  logic [sdve_pkg::DATA_W-1:0] ref_mem [SENSOR_COUNT];
  logic [SENSOR_COUNT-1:0]     known_r;
  logic [sdve_pkg::DATA_W-1:0] rd_value_r;
  logic                        rd_known_r;
  logic [AW-1:0]               rd_a;
  logic [AW-1:0]               wr_a;

  assign rd_a = AW'(rd_addr);
  assign wr_a = AW'(wr.addr);

  always_ff @(posedge clk) begin
    if (wr.en) begin
      ref_mem[wr_a] <= wr.data;
    end
    rd_value_r <= ref_mem[rd_a];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      known_r    <= '0;
      rd_known_r <= 1'b0;
    end else begin
      if (wr.en) begin
        known_r[wr_a] <= 1'b1;
      end
      rd_known_r <= known_r[rd_a];
    end
  end

  assign rd_value = rd_value_r;
  assign rd_known = rd_known_r;

endmodule

[rtl/core/sdve_alu.sv]
// ----------------------------------------------------------------------------
// sdve_alu
// Shared 32-bit subtractor with carry out; serves difference, negate and
// threshold compare in turn.
// ----------------------------------------------------------------------------
module sdve_alu (
  input  logic [sdve_pkg::DATA_W-1:0] op_a,
  input  logic [sdve_pkg::DATA_W-1:0] op_b,
  output logic [sdve_pkg::DATA_W-1:0] diff,
  output logic                        no_borrow
);

  logic [sdve_pkg::DATA_W:0] sum;

  assign sum       = {1'b0, op_a} + {1'b0, ~op_b} + (sdve_pkg::DATA_W + 1)'(1);
  assign diff      = sum[sdve_pkg::DATA_W-1:0];
  assign no_borrow = sum[sdve_pkg::DATA_W];

endmodule

[rtl/core/sdve_checker.sv]
// ----------------------------------------------------------------------------
// sdve_checker
// Port-level checks for the sensor delta varint encoder, bound to the top.
// ----------------------------------------------------------------------------
module sdve_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] out_byte,
  input logic       out_last_byte
);

  a_out_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("item dropped while stalled");

  a_out_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_byte) && $stable(out_last_byte))
    else $error("stalled item changed");

  a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("new item taken before previous one finished");

  a_last_no_more: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last_byte |-> !out_byte[7])
    else $error("final byte carries continuation flag");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_stall)
    else $error("not idle after reset");

endmodule

bind sensor_delta_varint_encoder sdve_checker u_sdve_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_valid),
  .in_stall      (in_stall),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .out_byte      (out_byte),
  .out_last_byte (out_last_byte)
);

[tb/sv/sensor_delta_varint_encoder_test.sv]
// ----------------------------------------------------------------------------
// sensor_delta_varint_encoder_test
// Drives delta and resync samples through the encoder under several register
// settings and idle patterns, predicts every record byte and compares each
// byte leaving the block with the oldest prediction.
// ----------------------------------------------------------------------------
class record_scoreboard;

  logic [30:0] threshold;
  logic [15:0] ignore_mask;
  logic [31:0] ref_val [sdve_pkg::SENSOR_COUNT];
  bit          ref_known [sdve_pkg::SENSOR_COUNT];
  logic [8:0]  expected_bytes [$];
  int          mismatches;

  function new();
    threshold   = 31'd1;
    ignore_mask = 16'h0000;
    mismatches  = 0;
    foreach (ref_val[i]) begin
      ref_val[i]   = '0;
      ref_known[i] = 1'b0;
    end
  endfunction

  function void write_reg(sdve_pkg::cfg_reg_t r, logic [30:0] v);
    if (r == sdve_pkg::REG_THRESHOLD) threshold = v;
    else ignore_mask = v[15:0];
  endfunction

  function void push_varint(logic [31:0] v);
    logic [31:0] z;
    z = {v[30:0], 1'b0} ^ {32{v[31]}};
    while (z >= 32'(sdve_pkg::MORE_FLAG)) begin
      expected_bytes.push_back({1'b0, sdve_pkg::MORE_FLAG | {1'b0, z[6:0]}});
      z = z >> 7;
    end
    expected_bytes.push_back({1'b1, 1'b0, z[6:0] & sdve_pkg::GROUP_MASK});
  endfunction

  function void note_sample(sdve_pkg::kind_t k, logic [3:0] idx, logic [31:0] v);
    logic [31:0] diff;
    logic [31:0] mag;
    if (idx >= sdve_pkg::SENSOR_COUNT) return;
    if (k == sdve_pkg::KIND_RESYNC) begin
      if (ignore_mask[idx]) return;
      expected_bytes.push_back({1'b0, sdve_pkg::RESYNC_MARK});
      expected_bytes.push_back({1'b0, 4'h0, idx});
      push_varint(v);
      ref_val[idx]   = v;
      ref_known[idx] = 1'b1;
      return;
    end
    if (!ref_known[idx]) begin
      ref_val[idx]   = v;
      ref_known[idx] = 1'b1;
      return;
    end
    diff = v - ref_val[idx];
    mag  = diff[31] ? -diff : diff;
    if (mag < {1'b0, threshold}) return;
    expected_bytes.push_back({1'b0, 4'h0, idx});
    push_varint(diff);
    ref_val[idx] = v;
  endfunction

  function void check_byte(logic [7:0] b, logic last);
    logic [8:0] want;
    if (expected_bytes.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("unexpected byte %02h last %0b", b, last);
      return;
    end
    want = expected_bytes.pop_front();
    if (want !== {last, b}) begin
      mismatches++;
      if (mismatches <= 10)
        $display("byte mismatch: expected %02h last %0b, got %02h last %0b",
                 want[7:0], want[8], b, last);
    end
  endfunction

endclass

module sensor_delta_varint_encoder_test;

  localparam int DRAIN_CYCLES   = 16;
  localparam int WATCHDOG_LIMIT = 4000;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic [sdve_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [sdve_pkg::CFG_DATA_W-1:0] cfg_wdata;
  logic in_valid;
  logic in_stall;
  logic in_kind;
  logic [sdve_pkg::IDX_W-1:0] in_sensor_index;
  logic signed [sdve_pkg::DATA_W-1:0] in_sample_value;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [7:0] out_byte;
  logic out_last_byte;

  record_scoreboard sb = new();
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int quiet_cycles = 0;

  sensor_delta_varint_encoder uut (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_kind        (in_kind),
    .in_sensor_index(in_sensor_index),
    .in_sample_value(in_sample_value),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_byte       (out_byte),
    .out_last_byte  (out_last_byte)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_byte(out_byte, out_last_byte);
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
      $display("FAIL sensor_delta_varint_encoder");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic set_config(logic [30:0] thr, logic [15:0] mask);
    cfg_we    <= 1'b1;
    cfg_index <= sdve_pkg::REG_THRESHOLD;
    cfg_wdata <= thr;
    @(posedge clk);
    sb.write_reg(sdve_pkg::REG_THRESHOLD, thr);
    cfg_index <= sdve_pkg::REG_IGNORE;
    cfg_wdata <= 31'(mask);
    @(posedge clk);
    sb.write_reg(sdve_pkg::REG_IGNORE, 31'(mask));
    cfg_we <= 1'b0;
  endtask

  task automatic send_sample(sdve_pkg::kind_t k, logic [3:0] idx, logic [31:0] v);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_kind         <= k;
    in_sensor_index <= idx;
    in_sample_value <= v;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_sample(k, idx, v);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (sb.expected_bytes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic run_random(int count);
    sdve_pkg::kind_t k;
    logic [3:0] idx;
    logic [31:0] v;
    logic [31:0] step;
    for (int i = 0; i < count; i++) begin
      k = ($urandom_range(99) < 25) ? sdve_pkg::KIND_RESYNC : sdve_pkg::KIND_DELTA;
      if ($urandom_range(99) < 10) idx = 4'($urandom_range(15, sdve_pkg::SENSOR_COUNT));
      else idx = 4'($urandom_range(sdve_pkg::SENSOR_COUNT - 1, 0));
      if (idx >= sdve_pkg::SENSOR_COUNT || $urandom_range(99) < 30) begin
        v = $urandom;
      end else begin
        step = $urandom >> $urandom_range(31, 0);
        if ($urandom_range(1) == 1) step = -step;
        v = sb.ref_val[idx] + step;
      end
      send_sample(k, idx, v);
    end
  endtask

  initial begin
    rst_n           <= 1'b0;
    cfg_we          <= 1'b0;
    cfg_index       <= sdve_pkg::REG_THRESHOLD;
    cfg_wdata       <= '0;
    in_valid        <= 1'b0;
    in_kind         <= sdve_pkg::KIND_DELTA;
    in_sensor_index <= '0;
    in_sample_value <= '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    set_config(31'd0, 16'h0204);
    send_sample(sdve_pkg::KIND_DELTA,  4'd0,  32'h7FFF_FFFF);
    send_sample(sdve_pkg::KIND_DELTA,  4'd0,  32'h7FFF_FFFF);
    send_sample(sdve_pkg::KIND_DELTA,  4'd0,  32'h8000_0000);
    send_sample(sdve_pkg::KIND_DELTA,  4'd1,  32'h0000_0000);
    send_sample(sdve_pkg::KIND_DELTA,  4'd1,  32'h8000_0000);
    send_sample(sdve_pkg::KIND_DELTA,  4'd1,  32'h7FFF_FFFF);
    send_sample(sdve_pkg::KIND_RESYNC, 4'd9,  32'h1234_5678);
    send_sample(sdve_pkg::KIND_DELTA,  4'd9,  32'h0000_0005);
    send_sample(sdve_pkg::KIND_RESYNC, 4'd2,  32'hFFFF_FFFF);
    send_sample(sdve_pkg::KIND_RESYNC, 4'd3,  32'h8000_0000);
    send_sample(sdve_pkg::KIND_RESYNC, 4'd4,  32'h7FFF_FFFF);
    send_sample(sdve_pkg::KIND_RESYNC, 4'd5,  32'hFFFF_FFFF);
    send_sample(sdve_pkg::KIND_RESYNC, 4'd6,  32'h0000_0000);
    send_sample(sdve_pkg::KIND_DELTA,  4'd10, 32'h0000_0001);
    send_sample(sdve_pkg::KIND_RESYNC, 4'd15, 32'hFFFF_FFFF);
    send_sample(sdve_pkg::KIND_DELTA,  4'd3,  32'h8000_0000);
    drain();

    set_config(31'h7FFF_FFFF, 16'h0000);
    send_sample(sdve_pkg::KIND_DELTA,  4'd1,  32'hFFFF_FFFF);
    send_sample(sdve_pkg::KIND_DELTA,  4'd0,  32'h0000_0000);
    send_sample(sdve_pkg::KIND_DELTA,  4'd5,  32'h7FFF_FFFE);
    send_sample(sdve_pkg::KIND_DELTA,  4'd6,  32'h7FFF_FFFE);
    send_sample(sdve_pkg::KIND_RESYNC, 4'd2,  32'h5555_5555);
    send_sample(sdve_pkg::KIND_RESYNC, 4'd9,  32'hAAAA_AAAA);
    send_sample(sdve_pkg::KIND_DELTA,  4'd7,  32'h0000_0040);
    send_sample(sdve_pkg::KIND_DELTA,  4'd7,  32'h0000_0000);
    drain();

    set_config(31'd0, 16'h0000);
    run_random(55);
    drain();

    send_idle_pct = 60;
    set_config(31'($urandom) >> $urandom_range(30, 8), 16'($urandom));
    run_random(55);
    drain();

    send_idle_pct  = 0;
    recv_stall_pct = 60;
    set_config(31'd1, 16'($urandom));
    run_random(55);
    drain();

    send_idle_pct  = 8;
    recv_stall_pct = 8;
    set_config(31'h7FFF_FFFF, 16'hFFFF);
    run_random(20);
    drain();
    set_config(31'($urandom_range(4095, 0)), 16'($urandom));
    run_random(40);
    drain();

    if (sb.mismatches == 0 && sb.expected_bytes.size() == 0) begin
      $display("PASS sensor_delta_varint_encoder");
    end else begin
      $display("FAIL sensor_delta_varint_encoder");
    end
    $finish;
  end

endmodule
